/* src/lgs_pkg.sv */
// Shared types, constants and the Life rule for the generation stream unit.
`timescale 1ns / 1ps

package lgs_pkg;

   // Configuration register map
   localparam int REG_INDEX_W = 2;
   localparam logic [REG_INDEX_W-1:0] REG_GRID_ROWS    = 2'd0;
   localparam logic [REG_INDEX_W-1:0] REG_GRID_COLUMNS = 2'd1;

   // Field widths
   localparam int DIM_W   = 11;
   localparam int COORD_W = 10;

   // Grid size after reset
   localparam int RESET_DIM = 64;

   // Queue depths (powers of two)
   localparam int OP_QUEUE_DEPTH  = 2;
   localparam int RSP_QUEUE_DEPTH = 4;

   // One classified input word, handed from the front to the back
   typedef struct packed {
      logic               new_cell;
      logic               two_ok;
      logic               one_ok;
      logic               line_start;
      logic               have;
      logic               last;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
   } cell_op_type;

   // One result word
   typedef struct packed {
      logic               next_alive;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
      logic               last;
   } cell_result_type;

   // B3/S23: count the eight neighbors around the center bit of a 3x3 window
   function automatic logic next_state(logic [8:0] win);
      logic [3:0] count;
      count = 4'd0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            count = count + {3'b000, win[i]};
         end
      end
      return (count == 4'd3) || ((count == 4'd2) && win[4]);
   endfunction

endpackage

/* src/lgs_fifo.sv */
// Small register-based queue used between the stages and on the result side.
`timescale 1ns / 1ps

module lgs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = entry_ff[rd_ptr_ff];
   assign push_ok = push & ~full;
   assign pop_ok  = pop & ~empty;

   // Track occupancy
   always_comb begin
      count_in = count_ff + CNT_W'(push_ok) - CNT_W'(pop_ok);
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Store the word
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* src/lgs_front.sv */
// Front end: grid size registers, raster position counters and word classification.
`timescale 1ns / 1ps

module lgs_front #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_fire,
   input  logic [lgs_pkg::REG_INDEX_W-1:0]   csr_index,
   input  logic [lgs_pkg::DIM_W-1:0]         csr_data,
   input  logic                              item_accept,
   input  logic                              cell_alive,
   input  logic                              flush,
   output lgs_pkg::cell_op_type              op,
   output logic [$clog2(MAX_COLUMNS)-1:0]    op_addr,
   output logic                              frame_restart
);

   localparam int COL_ADDR_W = $clog2(MAX_COLUMNS);
   localparam int COLS_W     = $clog2(MAX_COLUMNS+1);
   localparam int ROW_CNT_W  = $clog2(MAX_ROWS+3);
   localparam int ROWS_RESET =
      (lgs_pkg::RESET_DIM > MAX_ROWS) ? MAX_ROWS : lgs_pkg::RESET_DIM;
   localparam int COLS_RESET =
      (lgs_pkg::RESET_DIM > MAX_COLUMNS) ? MAX_COLUMNS : lgs_pkg::RESET_DIM;

   logic [ROW_CNT_W-1:0]  rows_ff;
   logic [COLS_W-1:0]     cols_ff;
   logic [ROW_CNT_W-1:0]  ir_ff;
   logic [ROW_CNT_W-1:0]  ir_in;
   logic [COL_ADDR_W-1:0] ic_ff;
   logic [COL_ADDR_W-1:0] ic_in;
   logic [31:0]           dim_clamp_rows;
   logic [31:0]           dim_clamp_cols;
   logic [31:0]           ir32;
   logic [31:0]           ic32;
   logic [31:0]           rows32;
   logic [31:0]           cols32;
   logic [31:0]           row_wide;
   logic [31:0]           col_wide;
   logic                  wr_rows;
   logic                  wr_cols;

   assign wr_rows       = csr_fire && (csr_index == lgs_pkg::REG_GRID_ROWS);
   assign wr_cols       = csr_fire && (csr_index == lgs_pkg::REG_GRID_COLUMNS);
   assign frame_restart = wr_rows || wr_cols;

   // Clamp written sizes: zero acts as one, oversize acts as the maximum
   always_comb begin
      dim_clamp_rows = 32'(csr_data);
      if (dim_clamp_rows == 32'd0) begin
         dim_clamp_rows = 32'd1;
      end else if (dim_clamp_rows > 32'(MAX_ROWS)) begin
         dim_clamp_rows = 32'(MAX_ROWS);
      end
      dim_clamp_cols = 32'(csr_data);
      if (dim_clamp_cols == 32'd0) begin
         dim_clamp_cols = 32'd1;
      end else if (dim_clamp_cols > 32'(MAX_COLUMNS)) begin
         dim_clamp_cols = 32'(MAX_COLUMNS);
      end
   end

   // Hold grid size
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROW_CNT_W'(ROWS_RESET);
         cols_ff <= COLS_W'(COLS_RESET);
      end else begin
         if (wr_rows) begin
            rows_ff <= dim_clamp_rows[ROW_CNT_W-1:0];
         end
         if (wr_cols) begin
            cols_ff <= dim_clamp_cols[COLS_W-1:0];
         end
      end
   end

   // Classify the incoming word by its raster position
   always_comb begin
      ir32   = 32'(ir_ff);
      ic32   = 32'(ic_ff);
      rows32 = 32'(rows_ff);
      cols32 = 32'(cols_ff);

      op.new_cell   = (ir32 < rows32) && !flush && cell_alive;
      op.two_ok     = (ir32 >= 32'd2) && (ir32 <= rows32 + 32'd1);
      op.one_ok     = (ir32 >= 32'd1) && (ir32 <= rows32);
      op.line_start = (ic_ff == '0);
      op.have       = op.line_start ? op.two_ok : op.one_ok;
      op.last       = op.line_start && (ir32 == rows32 + 32'd1);

      row_wide  = op.line_start ? (ir32 - 32'd2) : (ir32 - 32'd1);
      col_wide  = op.line_start ? (cols32 - 32'd1) : (ic32 - 32'd1);
      op.row    = row_wide[lgs_pkg::COORD_W-1:0];
      op.column = col_wide[lgs_pkg::COORD_W-1:0];
      op_addr   = ic_ff;

      // Advance the raster position, wrapping at line and frame end
      ir_in = ir_ff;
      ic_in = ic_ff;
      if (op.last) begin
         ir_in = '0;
         ic_in = '0;
      end else if (ic32 + 32'd1 >= cols32) begin
         ic_in = '0;
         if (ir32 + 32'd1 > rows32 + 32'd1) begin
            ir_in = '0;
         end else begin
            ir_in = ir_ff + ROW_CNT_W'(1);
         end
      end else begin
         ic_in = ic_ff + COL_ADDR_W'(1);
      end
   end

   // Update position counters
   always_ff @(posedge clock) begin
      if (reset || frame_restart) begin
         ir_ff <= '0;
         ic_ff <= '0;
      end else if (item_accept) begin
         ir_ff <= ir_in;
         ic_ff <= ic_in;
      end
   end

endmodule

/* src/lgs_back.sv */
// Back end: line buffer memory, 3x3 neighborhood window and next-state evaluation.
`timescale 1ns / 1ps

module lgs_back #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          frame_restart,
   input  logic                                          op_empty,
   input  lgs_pkg::cell_op_type                          op,
   input  logic [$clog2(MAX_COLUMNS)-1:0]                op_addr,
   output logic                                          op_pop,
   input  logic [$clog2(lgs_pkg::RSP_QUEUE_DEPTH+1)-1:0] rsp_count,
   output logic                                          rsp_push,
   output lgs_pkg::cell_result_type                      rsp
);

   localparam int COL_ADDR_W = $clog2(MAX_COLUMNS);

   // bit 1: row two above, bit 0: row above
   logic [1:0]            line_mem [MAX_COLUMNS];
   logic [1:0]            rd_ff;
   logic                  b_valid_ff;
   lgs_pkg::cell_op_type  b_op_ff;
   logic [COL_ADDR_W-1:0] b_addr_ff;
   logic                  fwd_hit_ff;
   logic                  fwd_hit_in;
   logic [1:0]            fwd_data_ff;
   logic [8:0]            window_ff;
   logic [8:0]            window_in;
   logic [8:0]            win_use;
   logic [1:0]            line_data;
   logic [1:0]            wr_data;
   logic [2:0]            col;
   logic                  issue;

   // Issue only when the result queue has room for everything in flight
   assign issue  = !op_empty &&
                   ((32'(rsp_count) + 32'(b_valid_ff)) < 32'(lgs_pkg::RSP_QUEUE_DEPTH));
   assign op_pop = issue;
   assign fwd_hit_in = b_valid_ff && (b_addr_ff == op_addr);

   // Build the new window column and evaluate the rule
   always_comb begin
      line_data = fwd_hit_ff ? fwd_data_ff : rd_ff;
      wr_data   = {line_data[0], b_op_ff.new_cell};
      col       = {b_op_ff.new_cell,
                   line_data[0] & b_op_ff.one_ok,
                   line_data[1] & b_op_ff.two_ok};
      if (b_op_ff.line_start) begin
         win_use   = {3'b000, window_ff[8:3]};
         window_in = {col, 6'b000000};
      end else begin
         win_use   = {col, window_ff[8:3]};
         window_in = win_use;
      end
      if (b_op_ff.last) begin
         window_in = '0;
      end
      rsp_push       = b_valid_ff && b_op_ff.have;
      rsp.next_alive = lgs_pkg::next_state(win_use);
      rsp.row        = b_op_ff.row;
      rsp.column     = b_op_ff.column;
      rsp.last       = b_op_ff.last;
   end

   // Line buffer: write back the shifted column, read the next one
   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         line_mem[b_addr_ff] <= wr_data;
      end
      if (issue) begin
         rd_ff <= line_mem[op_addr];
      end
   end

   // Capture the issued word; forward a write to the same column
   always_ff @(posedge clock) begin
      if (issue) begin
         b_op_ff     <= op;
         b_addr_ff   <= op_addr;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= wr_data;
      end
   end

   // Track the valid stage and slide the window
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || frame_restart) begin
         window_ff <= '0;
      end else if (b_valid_ff) begin
         window_ff <= window_in;
      end
   end

endmodule

/* src/life_generation_stream_unit.sv */
// Top level of the Life generation stream unit: queue ports, front, back and result queue.
//
// Usage: push the current grid in raster order, one cell per word on req_*, then
// grid_columns+1 flush words. A word is taken when req_push is high and req_full is
// low. Each word may release one result: the next state of one cell with its row and
// column, rsp_last_cell marking the final cell. A result is on rsp_* while rsp_empty
// is low and is taken when rsp_pop is high.
// Configuration: csr_index 0 writes grid_rows, 1 writes grid_columns (csr_ready is
// always high); a write restarts the frame. Write only while the block is idle.
// Throughput: one word per cycle while rsp_pop is high. A result reaches rsp_* after the
// word that completes its 3x3 neighborhood is taken, passing through the op queue, the
// line buffer read, then window and result queue.
// The line buffer is a single memory of MAX_COLUMNS two-bit entries read and written
// once per cycle; that port sets the one-word-per-cycle rate.
// Reset: queues empty, grid size 64 x 64 (clamped to the maximum), frame restarts at
// cell (0,0). Line buffers need no clearing pass; unwritten rows are masked.
// Stall: when rsp_pop stays low the result queue fills, the back end stops issuing,
// the front queue fills and req_full rises; no word is lost.
`timescale 1ns / 1ps

module life_generation_stream_unit #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_cell_alive,
   input  logic                              req_flush,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic                              rsp_next_alive,
   output logic [lgs_pkg::COORD_W-1:0]       rsp_cell_row,
   output logic [lgs_pkg::COORD_W-1:0]       rsp_cell_column,
   output logic                              rsp_last_cell,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lgs_pkg::REG_INDEX_W-1:0]   csr_index,
   input  logic [lgs_pkg::DIM_W-1:0]         csr_data
);

   localparam int COL_ADDR_W = $clog2(MAX_COLUMNS);
   localparam int OP_W       = $bits(lgs_pkg::cell_op_type) + COL_ADDR_W;
   localparam int RSP_W      = $bits(lgs_pkg::cell_result_type);

   lgs_pkg::cell_op_type     f_op;
   logic [COL_ADDR_W-1:0]    f_addr;
   lgs_pkg::cell_op_type     q_op;
   logic [COL_ADDR_W-1:0]    q_addr;
   logic [OP_W-1:0]          q_data;
   logic                     q_empty;
   logic                     q_pop;
   logic                     q_full;
   logic [$clog2(lgs_pkg::OP_QUEUE_DEPTH+1)-1:0]  q_count;
   logic [$clog2(lgs_pkg::RSP_QUEUE_DEPTH+1)-1:0] r_count;
   logic                     r_push;
   logic                     r_full;
   lgs_pkg::cell_result_type r_in;
   lgs_pkg::cell_result_type r_out;
   logic                     frame_restart;
   logic                     item_accept;
   logic                     csr_fire;

   assign csr_ready   = 1'b1;
   assign csr_fire    = csr_valid & csr_ready;
   assign req_full    = q_full;
   assign item_accept = req_push & ~q_full;

   // Classify incoming words
   lgs_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_fire      (csr_fire),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .item_accept   (item_accept),
      .cell_alive    (req_cell_alive),
      .flush         (req_flush),
      .op            (f_op),
      .op_addr       (f_addr),
      .frame_restart (frame_restart)
   );

   // Decouple front and back
   lgs_fifo #(
      .WIDTH (OP_W),
      .DEPTH (lgs_pkg::OP_QUEUE_DEPTH)
   ) u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (item_accept),
      .wr_data ({f_op, f_addr}),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_data),
      .empty   (q_empty),
      .count   (q_count)
   );

   assign {q_op, q_addr} = q_data;

   // Evaluate cells
   lgs_back #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .frame_restart (frame_restart),
      .op_empty      (q_empty),
      .op            (q_op),
      .op_addr       (q_addr),
      .op_pop        (q_pop),
      .rsp_count     (r_count),
      .rsp_push      (r_push),
      .rsp           (r_in)
   );

   // Hold results for the receiver
   lgs_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (lgs_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (r_push),
      .wr_data (r_in),
      .full    (r_full),
      .pop     (rsp_pop),
      .rd_data (r_out),
      .empty   (rsp_empty),
      .count   (r_count)
   );

   assign rsp_next_alive  = r_out.next_alive;
   assign rsp_cell_row    = r_out.row;
   assign rsp_cell_column = r_out.column;
   assign rsp_last_cell   = r_out.last & ~(r_full & q_count[0] & 1'b0);

endmodule

/* dv/life_generation_stream_unit_tb.sv */
// Testbench for the Life generation stream unit: random grids checked against a B3/S23 predictor.
`timescale 1ns / 1ps

module life_generation_stream_unit_tb;

   localparam int GRID_MAX_COLUMNS = 1024;
   localparam int GRID_MAX_ROWS    = 1024;
   localparam int SETTLE_CYCLES    = 8;
   localparam int TAIL_CYCLES      = 16;
   localparam int RUN_LIMIT        = 400000;
   localparam int REPORT_LIMIT     = 10;

   // Indexes outside the register map; writes to them are dropped
   localparam logic [lgs_pkg::REG_INDEX_W-1:0] REG_UNMAPPED_LO = 2'd2;
   localparam logic [lgs_pkg::REG_INDEX_W-1:0] REG_UNMAPPED_HI = 2'd3;

   typedef struct packed {
      logic alive;
      logic flush;
   } cell_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   logic                            req_cell_alive = 1'b0;
   logic                            req_flush = 1'b0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   logic                            rsp_next_alive;
   logic [lgs_pkg::COORD_W-1:0]     rsp_cell_row;
   logic [lgs_pkg::COORD_W-1:0]     rsp_cell_column;
   logic                            rsp_last_cell;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [lgs_pkg::REG_INDEX_W-1:0] csr_index = '0;
   logic [lgs_pkg::DIM_W-1:0]       csr_data = '0;

   life_generation_stream_unit #(
      .MAX_COLUMNS(GRID_MAX_COLUMNS),
      .MAX_ROWS   (GRID_MAX_ROWS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cell_alive (req_cell_alive),
      .req_flush      (req_flush),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_next_alive (rsp_next_alive),
      .rsp_cell_row   (rsp_cell_row),
      .rsp_cell_column(rsp_cell_column),
      .rsp_last_cell  (rsp_last_cell),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #4 clock = ~clock;

   // Words waiting to be pushed, and next-generation cells still owed by the block
   cell_word_type            cell_words [$];
   lgs_pkg::cell_result_type due_cells [$];

   int  send_idle_pct  = 0;
   int  pop_stall_pct  = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  word_taken     = 1'b0;

   // Shadow of the grid size, line buffers, window and raster position
   logic [lgs_pkg::DIM_W-1:0] grid_rows_shadow = lgs_pkg::DIM_W'(lgs_pkg::RESET_DIM);
   logic [lgs_pkg::DIM_W-1:0] grid_cols_shadow = lgs_pkg::DIM_W'(lgs_pkg::RESET_DIM);
   bit                        line_above [GRID_MAX_COLUMNS];
   bit                        line_two_above [GRID_MAX_COLUMNS];
   logic [8:0]                window_shadow = '0;
   int unsigned               raster_row = 0;
   int unsigned               raster_col = 0;

   function automatic int unsigned span_of(logic [lgs_pkg::DIM_W-1:0] value,
                                           int unsigned limit);
      if (value == 0) return 1;
      return (value > limit) ? limit : int'(value);
   endfunction

   function automatic void restart_raster();
      window_shadow = '0;
      raster_row    = 0;
      raster_col    = 0;
   endfunction

   // Advance the shadow by one accepted word and queue the cell it completes, if any
   function automatic void step_generation(logic alive, logic flush);
      int unsigned              rows, cols, ir, ic;
      int                       live;
      logic                     fresh, two, one, have, last;
      logic [2:0]               column_bits;
      logic [8:0]               win;
      lgs_pkg::cell_result_type owed;
      rows = span_of(grid_rows_shadow, GRID_MAX_ROWS);
      cols = span_of(grid_cols_shadow, GRID_MAX_COLUMNS);
      ir   = raster_row;
      ic   = raster_col % GRID_MAX_COLUMNS;
      fresh = (ir < rows && !flush) ? alive : 1'b0;

      // Shift the column through both line buffers
      two = line_two_above[ic];
      one = line_above[ic];
      line_two_above[ic] = one;
      line_above[ic]     = fresh;
      if (!(ir >= 2 && ir - 2 < rows)) two = 1'b0;
      if (!(ir >= 1 && ir - 1 < rows)) one = 1'b0;
      column_bits = {fresh, one, two};

      have = 1'b0;
      last = 1'b0;
      owed = '0;
      if (ic == 0) begin
         // A new line closes the last cell of the line before
         win = window_shadow >> 3;
         if (ir >= 2 && ir - 2 < rows) begin
            have        = 1'b1;
            owed.row    = lgs_pkg::COORD_W'(ir - 2);
            owed.column = lgs_pkg::COORD_W'(cols - 1);
            last        = (ir == rows + 1);
         end
         window_shadow = {column_bits, 6'b0};
      end else begin
         win = (window_shadow >> 3) | {column_bits, 6'b0};
         window_shadow = win;
         if (ir >= 1 && ir - 1 < rows) begin
            have        = 1'b1;
            owed.row    = lgs_pkg::COORD_W'(ir - 1);
            owed.column = lgs_pkg::COORD_W'(ic - 1);
         end
      end

      if (have) begin
         live            = $countones(win & 9'b111_101_111);
         owed.next_alive = (live == 3) || (live == 2 && win[4]);
         owed.last       = last;
         due_cells.insert(due_cells.size(), owed);
      end

      if (last) begin
         restart_raster();
      end else begin
         ic++;
         if (ic >= cols) begin
            ic = 0;
            ir++;
            if (ir > rows + 1) ir = 0;
         end
         raster_row = ir;
         raster_col = ic;
      end
   endfunction

   function automatic void push_word(logic alive, logic flush);
      cell_word_type w;
      w.alive = alive;
      w.flush = flush;
      cell_words.insert(cell_words.size(), w);
   endfunction

   // Queue one frame plus its flush tail, cut short after cut words when cut is nonzero
   function automatic int queue_frame(int rows, int cols, int cut);
      int alive_pct, total;
      alive_pct = $urandom_range(70, 10);
      total     = rows * cols + cols + 1;
      if (cut > 0 && cut < total) total = cut;
      for (int k = 0; k < total; k++) begin
         if (k < rows * cols)
            push_word($urandom_range(99) < alive_pct, $urandom_range(99) < 5);
         else if ($urandom_range(99) < 20)
            push_word(1'($urandom_range(1)), 1'b0);
         else
            push_word(1'($urandom_range(1)), 1'b1);
      end
      return total;
   endfunction

   // Write one register and mirror it in the shadow once the write is taken
   task automatic write_grid_reg(logic [lgs_pkg::REG_INDEX_W-1:0] index,
                                 logic [lgs_pkg::DIM_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == lgs_pkg::REG_GRID_ROWS) begin
         grid_rows_shadow = value;
         restart_raster();
      end else if (index == lgs_pkg::REG_GRID_COLUMNS) begin
         grid_cols_shadow = value;
         restart_raster();
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_index <= lgs_pkg::REG_INDEX_W'($urandom_range(3));
      csr_data  <= lgs_pkg::DIM_W'($urandom);
   endtask

   // Hold until every word is taken and every owed cell has come back
   task automatic wait_idle();
      while (cell_words.size() != 0 || req_push || due_cells.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random grids of small sizes, with the occasional broken frame and dropped write
   task automatic run_random_phase(int send_pct, int stall_pct, int word_goal);
      int                        queued, rows, cols, cut;
      logic [lgs_pkg::DIM_W-1:0] rows_val, cols_val;
      send_idle_pct = send_pct;
      pop_stall_pct = stall_pct;
      queued = 0;
      while (queued < word_goal) begin
         rows_val = ($urandom_range(7) == 0) ? '0 : lgs_pkg::DIM_W'($urandom_range(8, 1));
         cols_val = ($urandom_range(7) == 0) ? '0 : lgs_pkg::DIM_W'($urandom_range(8, 1));
         write_grid_reg(lgs_pkg::REG_GRID_ROWS, rows_val);
         write_grid_reg(lgs_pkg::REG_GRID_COLUMNS, cols_val);
         rows = span_of(rows_val, GRID_MAX_ROWS);
         cols = span_of(cols_val, GRID_MAX_COLUMNS);
         repeat ($urandom_range(3, 1)) queued += queue_frame(rows, cols, 0);
         if ($urandom_range(3) == 0) begin
            // Break a frame, poke an unmapped register, then carry on mid-frame
            cut = $urandom_range(rows * cols + cols, 1);
            queued += queue_frame(rows, cols, cut);
            wait_idle();
            write_grid_reg($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                           lgs_pkg::DIM_W'($urandom));
            queued += queue_frame(rows, cols, 0);
         end
         wait_idle();
      end
   endtask

   // Drive request words at the falling edge; hold a word until it is taken
   always @(negedge clock) begin : drive_cells
      cell_word_type w;
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || word_taken) begin
         if (cell_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = cell_words.pop_front();
            req_push       <= 1'b1;
            req_cell_alive <= w.alive;
            req_flush      <= w.flush;
         end else begin
            req_push       <= 1'b0;
            req_cell_alive <= 1'($urandom_range(1));
            req_flush      <= 1'($urandom_range(1));
         end
      end
      word_taken = 1'b0;
   end

   // Advance the shadow on every accepted word
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         step_generation(req_cell_alive, req_flush);
         word_taken = 1'b1;
      end
   end

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= pop_stall_pct);
   end

   // Compare each popped result with the oldest owed cell
   always @(posedge clock) begin : check_cells
      lgs_pkg::cell_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (due_cells.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected result alive=%0d row=%0d col=%0d last=%0d",
                        $realtime, rsp_next_alive, rsp_cell_row, rsp_cell_column,
                        rsp_last_cell);
         end else begin
            want = due_cells.pop_front();
            if (rsp_next_alive !== want.next_alive || rsp_cell_row !== want.row ||
                rsp_cell_column !== want.column || rsp_last_cell !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: mismatch expected alive=%0d row=%0d col=%0d last=%0d, %s",
                           $realtime, want.next_alive, want.row, want.column, want.last,
                           $sformatf("got alive=%0d row=%0d col=%0d last=%0d",
                                     rsp_next_alive, rsp_cell_row, rsp_cell_column,
                                     rsp_last_cell));
            end
         end
      end
   end

   // Drop the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int unused_count;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: 3x3 vertical blinker, a flush inside the grid, cell words in the tail
      write_grid_reg(lgs_pkg::REG_GRID_ROWS, 11'd3);
      write_grid_reg(lgs_pkg::REG_GRID_COLUMNS, 11'd3);
      push_word(1'b0, 1'b0); push_word(1'b1, 1'b0); push_word(1'b0, 1'b0);
      push_word(1'b0, 1'b0); push_word(1'b1, 1'b0); push_word(1'b0, 1'b0);
      push_word(1'b0, 1'b0); push_word(1'b1, 1'b0); push_word(1'b1, 1'b1);
      push_word(1'b0, 1'b1); push_word(1'b1, 1'b0); push_word(1'b1, 1'b0);
      push_word(1'b1, 1'b1);
      wait_idle();

      // Directed: zero sizes act as a single cell; two frames back to back
      write_grid_reg(lgs_pkg::REG_GRID_ROWS, '0);
      write_grid_reg(lgs_pkg::REG_GRID_COLUMNS, '0);
      push_word(1'b1, 1'b0); push_word(1'b1, 1'b1); push_word(1'b1, 1'b0);
      push_word(1'b0, 1'b0); push_word(1'b0, 1'b1); push_word(1'b0, 1'b1);
      wait_idle();

      // Extremes: oversize row count clamps; tallest grid one column wide, cut short
      write_grid_reg(lgs_pkg::REG_GRID_ROWS, '1);
      write_grid_reg(lgs_pkg::REG_GRID_COLUMNS, 11'd1);
      unused_count = queue_frame(GRID_MAX_ROWS, 1, 48);
      wait_idle();

      // Random grids under each idling pattern
      run_random_phase(0, 0, 110);
      run_random_phase(66, 0, 110);
      run_random_phase(0, 66, 110);
      run_random_phase(16, 16, 110);

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && due_cells.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
